>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lpw_pkg.sv
// Types, constants and helpers for the laser point to world transform.
package lpw_pkg;

   localparam int ANGLE_BITS = 24;
   localparam int MAX_BEAMS  = 2048;

   // trig values, Q1.17 with room for +1.0
   localparam int TRIG_W = 19;
   typedef logic signed [TRIG_W-1:0] trig_type;
   localparam int TRIG_ONE = 131072;
   localparam int TRIG_LAT = 10;

   // sine evaluation constants, Q30
   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
   localparam logic [30:0] Q30_C9     = 31'd2959;
   localparam logic [30:0] HORNER_C [4] = '{31'd213044, 31'd8947849, 31'd178956971,
                                           31'd1073741824};

   // register map
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ANGLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAM_STEP     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLATFORM_STEP = 2'd2;
   localparam logic [23:0] START_ANGLE_RST   = 24'hA00000;
   localparam logic [23:0] BEAM_STEP_RST     = 24'd11651;
   localparam logic [23:0] PLATFORM_STEP_RST = 24'd0;

   // Q1.22 rotation coefficients, mm Q.12 translation
   typedef logic signed [23:0] coef_type;
   localparam coef_type LP_ROT [3][2] = '{'{ 24'sd4192860,  24'sd109810},
                                          '{-24'sd109873,  24'sd4192675},
                                          '{ 24'sd6084,    24'sd40018}};
   localparam coef_type PR_ROT [3][3] = '{'{ 24'sd4194062,  24'sd25841,   24'sd36877},
                                          '{-24'sd25739,   24'sd4194208, -24'sd11782},
                                          '{-24'sd36949,   24'sd11555,   24'sd4194125}};
   localparam coef_type PR_TRANS [3] = '{-24'sd586893, -24'sd39380, 24'sd2355886};
   localparam int LASER_OFFSET = -16384;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
   } pose_type;

   function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
      logic signed [23:0] r;
      if (v > 42'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -42'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/lpw_sincos.sv
// Pipelined sine and cosine of one binary angle, Q1.17 results.
module lpw_sincos #(
   parameter int ANGLE_BITS = lpw_pkg::ANGLE_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] phase,
   output lpw_pkg::trig_type     sin_q,
   output lpw_pkg::trig_type     cos_q
);

   localparam int UW = ANGLE_BITS - 1;
   localparam logic [UW-1:0] QUARTER = {1'b1, {(ANGLE_BITS-2){1'b0}}};
   localparam logic [16:0] C_LO = lpw_pkg::TWO_PI_Q30[16:0];
   localparam logic [15:0] C_HI = lpw_pkg::TWO_PI_Q30[32:17];

   logic [1:0]            quad;
   logic [ANGLE_BITS-3:0] u;
   lpw_pkg::trig_type     lane_q [2];

   assign quad  = phase[ANGLE_BITS-1 -: 2];
   assign u     = phase[ANGLE_BITS-3:0];
   assign sin_q = lane_q[0];
   assign cos_q = lane_q[1];

   // lane 0 is sine, lane 1 is cosine (a quarter turn ahead)
   for (genvar lane = 0; lane < 2; lane++) begin : g_lane
      logic [1:0]        q;
      logic [UW-1:0]     ua_in, ua_ff;
      logic [8:0]        neg_ff;
      logic [UW+16:0]    plo_ff;
      logic [UW+15:0]    phi_ff;
      logic [UW+32:0]    xsum;
      logic [30:0]       x_ff [6];
      logic [61:0]       xx;
      logic [31:0]       x2_ff [4];
      logic [62:0]       tp [4];
      logic [30:0]       t_in [4];
      logic [30:0]       t_ff [4];
      logic [61:0]       sp;
      logic [30:0]       s_ff;
      logic [31:0]       rs;
      logic [18:0]       r, rsat;
      lpw_pkg::trig_type trig_in, trig_ff;

      assign q     = quad + 2'(lane);
      assign ua_in = q[0] ? (QUARTER - UW'(u)) : UW'(u);
      assign xsum  = {phi_ff, 17'b0} + (UW+33)'(plo_ff);
      assign xx    = x_ff[0] * x_ff[0];

      for (genvar k = 0; k < 4; k++) begin : g_horner
         if (k == 0) begin : g_first
            assign tp[k] = x2_ff[k] * lpw_pkg::Q30_C9;
         end else begin : g_next
            assign tp[k] = x2_ff[k] * t_ff[k-1];
         end
         assign t_in[k] = lpw_pkg::HORNER_C[k] - tp[k][60:30];
      end

      assign sp      = x_ff[5] * t_ff[3];
      assign rs      = 32'(s_ff) + 32'd4096;
      assign r       = rs[31:13];
      assign rsat    = (r > 19'(lpw_pkg::TRIG_ONE)) ? 19'(lpw_pkg::TRIG_ONE) : r;
      assign trig_in = neg_ff[8] ? -$signed(rsat) : $signed(rsat);

      always_ff @(posedge clock) begin
         if (en) begin
            ua_ff    <= ua_in;
            neg_ff   <= {neg_ff[7:0], q[1]};
            plo_ff   <= ua_ff * C_LO;
            phi_ff   <= ua_ff * C_HI;
            x_ff[0]  <= xsum[ANGLE_BITS +: 31];
            for (int i = 1; i < 6; i++) begin
               x_ff[i] <= x_ff[i-1];
            end
            x2_ff[0] <= xx[61:30];
            for (int i = 1; i < 4; i++) begin
               x2_ff[i] <= x2_ff[i-1];
            end
            for (int i = 0; i < 4; i++) begin
               t_ff[i] <= t_in[i];
            end
            s_ff     <= sp[60:30];
            trig_ff  <= trig_in;
         end
      end

      assign lane_q[lane] = trig_ff;
   end

endmodule

>>> hw/rtl/laser_point_to_world_transform_top.sv
// Top level of the laser point to world transform pipeline.
//
//  channel | ports               | direction | word
//  --------+---------------------+-----------+---------------------------------
//  req     | req_valid/req_ready | in        | range, beam, scan, pose x/y/z/yaw
//  rsp     | rsp_valid/rsp_ready | out       | world point x/y/z in mm
//  csr     | csr_write_en        | in        | register index and 24-bit data
//
// One word enters per cycle unless the pipeline holds; a word's result leaves
// after stage 0, the 10-stage sine/cosine pipeline and the 10 matrix stages.
// All stages advance together; when a result waits on rsp_ready the whole
// pipeline holds, and req_ready drops with it.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// No word is dropped or repeated across a stall.

`include "assert_macros.svh"

module laser_point_to_world_transform_top #(
   parameter int ANGLE_BITS = lpw_pkg::ANGLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [15:0]                         req_range_mm,
   input  logic [10:0]                         req_beam_index,
   input  logic [15:0]                         req_scan_index,
   input  logic signed [23:0]                  req_pose_x,
   input  logic signed [23:0]                  req_pose_y,
   input  logic signed [23:0]                  req_pose_z,
   input  logic signed [23:0]                  req_pose_yaw,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [23:0]                  rsp_point_x,
   output logic signed [23:0]                  rsp_point_y,
   output logic signed [23:0]                  rsp_point_z,
   input  logic                                csr_write_en,
   input  logic [lpw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [23:0]                         csr_data
);

   localparam int TRIG_STAGE = lpw_pkg::TRIG_LAT;
   localparam int LAST       = TRIG_STAGE + 10;
   localparam lpw_pkg::trig_type TRIG_MAX = lpw_pkg::trig_type'(lpw_pkg::TRIG_ONE);
   localparam lpw_pkg::trig_type TRIG_MIN = -TRIG_MAX;

   // configuration registers
   logic [23:0] start_angle_ff, beam_step_ff, platform_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff   <= lpw_pkg::START_ANGLE_RST;
         beam_step_ff     <= lpw_pkg::BEAM_STEP_RST;
         platform_step_ff <= lpw_pkg::PLATFORM_STEP_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            lpw_pkg::CSR_START_ANGLE:   start_angle_ff   <= csr_data;
            lpw_pkg::CSR_BEAM_STEP:     beam_step_ff     <= csr_data;
            lpw_pkg::CSR_PLATFORM_STEP: platform_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // global advance: the output stage is free or is being emptied
   logic            en;
   logic [LAST:0]   vld_ff;

   assign en        = !vld_ff[LAST] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   // stage 0: beam, platform and yaw angles, turn-wrapped, rescaled
   logic [10:0]           beam_c;
   logic [23:0]           theta24, plat24;
   logic [ANGLE_BITS-1:0] theta_in, plat_in, yaw_in;
   logic [ANGLE_BITS-1:0] theta_ff, plat_ff, yaw_ff;

   assign beam_c  = ({2'b0, req_beam_index} >= 13'(lpw_pkg::MAX_BEAMS))
                    ? 11'(lpw_pkg::MAX_BEAMS - 1) : req_beam_index;
   assign theta24 = start_angle_ff + 24'(beam_c * beam_step_ff);
   assign plat24  = 24'(req_scan_index * platform_step_ff);

   if (ANGLE_BITS >= 24) begin : g_widen
      assign theta_in = ANGLE_BITS'(theta24) << (ANGLE_BITS - 24);
      assign plat_in  = ANGLE_BITS'(plat24) << (ANGLE_BITS - 24);
      assign yaw_in   = ANGLE_BITS'(req_pose_yaw[23:0]) << (ANGLE_BITS - 24);
   end else begin : g_narrow
      assign theta_in = theta24[23 -: ANGLE_BITS];
      assign plat_in  = plat24[23 -: ANGLE_BITS];
      assign yaw_in   = req_pose_yaw[23 -: ANGLE_BITS];
   end

   // carried payload
   logic [15:0]       range_ff [TRIG_STAGE+1];
   lpw_pkg::pose_type pose_ff  [LAST];

   always_ff @(posedge clock) begin
      if (en) begin
         theta_ff    <= theta_in;
         plat_ff     <= plat_in;
         yaw_ff      <= yaw_in;
         range_ff[0] <= req_range_mm;
         pose_ff[0]  <= '{x: req_pose_x, y: req_pose_y, z: req_pose_z};
         for (int i = 1; i <= TRIG_STAGE; i++) begin
            range_ff[i] <= range_ff[i-1];
         end
         for (int i = 1; i < LAST; i++) begin
            pose_ff[i] <= pose_ff[i-1];
         end
      end
   end

   // stages 1..10: three trig units side by side
   lpw_pkg::trig_type theta_sin, theta_cos, plat_sin, plat_cos, yaw_sin, yaw_cos;

   lpw_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_theta_trig (
      .clock(clock), .en(en), .phase(theta_ff), .sin_q(theta_sin), .cos_q(theta_cos));
   lpw_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_plat_trig (
      .clock(clock), .en(en), .phase(plat_ff), .sin_q(plat_sin), .cos_q(plat_cos));
   lpw_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw_trig (
      .clock(clock), .en(en), .phase(yaw_ff), .sin_q(yaw_sin), .cos_q(yaw_cos));

   // stage 11: polar to Cartesian, mm Q.12
   logic signed [35:0] pxl, pyl, rxl, ryl;
   logic signed [30:0] xl_ff, yl_ff;

   assign pxl = $signed({1'b0, range_ff[TRIG_STAGE]}) * theta_cos;
   assign pyl = $signed({1'b0, range_ff[TRIG_STAGE]}) * theta_sin;
   assign rxl = pxl + 36'sd16;
   assign ryl = pyl + 36'sd16;

   // stage 12/13: laser-to-platform rotation and laser offset
   logic signed [54:0] p_in [6];
   logic signed [54:0] p_ff [6];
   logic signed [55:0] rvs  [3];
   logic signed [31:0] rv_in [3];
   logic signed [31:0] rv_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_lp
      assign p_in[2*i]   = lpw_pkg::LP_ROT[i][0] * xl_ff;
      assign p_in[2*i+1] = lpw_pkg::LP_ROT[i][1] * yl_ff;
      assign rvs[i]      = 56'(p_ff[2*i]) + 56'(p_ff[2*i+1]) + 56'sd2097152;
   end
   assign rv_in[0] = 32'(rvs[0] >>> 22);
   assign rv_in[1] = 32'(rvs[1] >>> 22);
   assign rv_in[2] = 32'(rvs[2] >>> 22) + 32'(lpw_pkg::LASER_OFFSET);

   // stage 14/15: platform rotation
   lpw_pkg::trig_type  cpd_ff [3], spd_ff [3];
   logic signed [50:0] q_in [4];
   logic signed [50:0] q_ff [4];
   logic signed [31:0] rv0_ff;
   logic signed [51:0] ys0, ys1;
   logic signed [32:0] yt_in [3];
   logic signed [32:0] yt_ff [3];

   assign q_in[0] = rv_ff[1] * cpd_ff[2];
   assign q_in[1] = rv_ff[2] * spd_ff[2];
   assign q_in[2] = rv_ff[1] * spd_ff[2];
   assign q_in[3] = rv_ff[2] * cpd_ff[2];
   assign ys0 = -52'(q_ff[0]) + 52'(q_ff[1]) + 52'sd65536;
   assign ys1 = -52'(q_ff[2]) - 52'(q_ff[3]) + 52'sd65536;
   assign yt_in[0] = 33'(ys0 >>> 17);
   assign yt_in[1] = 33'(ys1 >>> 17);
   assign yt_in[2] = 33'(rv0_ff);

   // stage 16/17: platform-to-robot rotation and translation
   logic signed [56:0] m_in [9];
   logic signed [56:0] m_ff [9];
   logic signed [58:0] rbs  [3];
   logic signed [35:0] rb_in [3];
   logic signed [35:0] rb_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_pr
      for (genvar j = 0; j < 3; j++) begin : g_col
         assign m_in[3*i+j] = lpw_pkg::PR_ROT[i][j] * yt_ff[j];
      end
      assign rbs[i]   = 59'(m_ff[3*i]) + 59'(m_ff[3*i+1]) + 59'(m_ff[3*i+2])
                        + 59'sd2097152;
      assign rb_in[i] = 36'(rbs[i] >>> 22) + 36'(lpw_pkg::PR_TRANS[i]);
   end

   // stage 18/19: robot yaw rotation
   lpw_pkg::trig_type  cyd_ff [7], syd_ff [7];
   logic signed [54:0] w_in [4];
   logic signed [54:0] w_ff [4];
   logic signed [35:0] rb2_ff [2];
   logic signed [55:0] xs, ys;
   logic signed [39:0] xe_ff, ye_ff;

   assign w_in[0] = rb_ff[0] * cyd_ff[6];
   assign w_in[1] = rb_ff[1] * syd_ff[6];
   assign w_in[2] = rb_ff[0] * syd_ff[6];
   assign w_in[3] = rb_ff[1] * cyd_ff[6];
   assign xs = 56'(w_ff[0]) - 56'(w_ff[1]) + 56'sd65536;
   assign ys = 56'(w_ff[2]) + 56'(w_ff[3]) + 56'sd65536;

   // stage 20: back to whole mm, add the pose, saturate
   logic signed [40:0] xr, yr;
   logic signed [36:0] zr;
   logic signed [23:0] point_x_ff, point_y_ff, point_z_ff;

   assign xr = 41'(xe_ff) + 41'sd2048;
   assign yr = 41'(ye_ff) + 41'sd2048;
   assign zr = 37'(rb2_ff[1]) + 37'sd2048;

   always_ff @(posedge clock) begin
      if (en) begin
         xl_ff     <= 31'(rxl >>> 5);
         yl_ff     <= 31'(ryl >>> 5);
         cpd_ff[0] <= plat_cos;
         spd_ff[0] <= plat_sin;
         for (int i = 1; i < 3; i++) begin
            cpd_ff[i] <= cpd_ff[i-1];
            spd_ff[i] <= spd_ff[i-1];
         end
         cyd_ff[0] <= yaw_cos;
         syd_ff[0] <= yaw_sin;
         for (int i = 1; i < 7; i++) begin
            cyd_ff[i] <= cyd_ff[i-1];
            syd_ff[i] <= syd_ff[i-1];
         end
         for (int i = 0; i < 6; i++) begin
            p_ff[i] <= p_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            rv_ff[i] <= rv_in[i];
            yt_ff[i] <= yt_in[i];
            rb_ff[i] <= rb_in[i];
         end
         for (int i = 0; i < 4; i++) begin
            q_ff[i] <= q_in[i];
            w_ff[i] <= w_in[i];
         end
         for (int i = 0; i < 9; i++) begin
            m_ff[i] <= m_in[i];
         end
         rv0_ff     <= rv_ff[0];
         rb2_ff[0]  <= rb_ff[2];
         rb2_ff[1]  <= rb2_ff[0];
         xe_ff      <= 40'(xs >>> 17);
         ye_ff      <= 40'(ys >>> 17);
         point_x_ff <= lpw_pkg::sat24(42'(xr >>> 12) + 42'(pose_ff[LAST-1].x));
         point_y_ff <= lpw_pkg::sat24(42'(yr >>> 12) + 42'(pose_ff[LAST-1].y));
         point_z_ff <= lpw_pkg::sat24(42'(zr >>> 12) + 42'(pose_ff[LAST-1].z));
      end
   end

   assign rsp_point_x = point_x_ff;
   assign rsp_point_y = point_y_ff;
   assign rsp_point_z = point_z_ff;

   // checks
   `ASSERT_CLK(a_trig_bounded, clock, reset, vld_ff[TRIG_STAGE] |-> (theta_cos <= TRIG_MAX && theta_cos >= TRIG_MIN && theta_sin <= TRIG_MAX && theta_sin >= TRIG_MIN), "beam sine or cosine beyond unit range")
   `ASSERT_CLK(a_stall_holds, clock, reset, !en |=> $stable(vld_ff), "pipeline valid bits moved during a stall")
   `ASSERT_CLK_NORST(a_reset_empty, clock, reset |=> !rsp_valid, "result word presented straight after reset")

endmodule

>>> sim/laser_point_to_world_transform_checker.sv
// Checker for the laser point to world transform: predicts each world point and compares.
`timescale 1ns / 1ps
`default_nettype none

module laser_point_to_world_transform_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [15:0]        req_range_mm,
   input  wire logic [10:0]        req_beam_index,
   input  wire logic [15:0]        req_scan_index,
   input  wire logic signed [23:0] req_pose_x,
   input  wire logic signed [23:0] req_pose_y,
   input  wire logic signed [23:0] req_pose_z,
   input  wire logic signed [23:0] req_pose_yaw,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [23:0] rsp_point_x,
   input  wire logic signed [23:0] rsp_point_y,
   input  wire logic signed [23:0] rsp_point_z,
   input  wire logic               csr_write_en,
   input  wire logic [lpw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [23:0]        csr_data,
   output int                      fail_count,
   output int                      points_pending,
   output int                      points_seen
);

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
   } point_type;

   localparam longint LP_M [3][2] = '{'{4192860, 109810}, '{-109873, 4192675}, '{6084, 40018}};
   localparam longint PR_M [3][3] = '{'{4194062, 25841, 36877},
                                      '{-25739, 4194208, -11782},
                                      '{-36949, 11555, 4194125}};
   localparam longint PR_T [3] = '{-586893, -39380, 2355886};

   // ring of predicted points, far deeper than the pipeline
   point_type   expected_mem [64];
   logic [5:0]  wr_ptr, rd_ptr;
   logic [23:0] start_ang, beam_step, plat_step;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint quarter_sine(longint unsigned u);
      longint unsigned x, x2, t, s;
      x  = (u * 64'd6746518852) >> 24;
      x2 = (x * x) >> 30;
      t  = 2959;
      t  = 213044 - ((x2 * t) >> 30);
      t  = 8947849 - ((x2 * t) >> 30);
      t  = 178956971 - ((x2 * t) >> 30);
      t  = 1073741824 - ((x2 * t) >> 30);
      s  = (x * t) >> 30;
      s  = (s + 4096) >> 13;
      if (s > 131072) s = 131072;
      return longint'(s);
   endfunction

   function automatic longint sine_of(logic [23:0] ph);
      logic [21:0] u;
      longint      v;
      u = ph[21:0];
      v = ph[22] ? quarter_sine(64'd4194304 - u) : quarter_sine(u);
      return ph[23] ? -v : v;
   endfunction

   function automatic longint cosine_of(logic [23:0] ph);
      return sine_of(ph + 24'h400000);
   endfunction

   function automatic logic signed [23:0] clamp24(longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   function automatic point_type world_point(logic [15:0] range, logic [10:0] beam,
                                             logic [15:0] scan, logic signed [23:0] px,
                                             logic signed [23:0] py, logic signed [23:0] pz,
                                             logic [23:0] yaw);
      logic [23:0] theta, plat;
      longint ct, st, cp, sp, cy, sy, xl, yl, xe, ye;
      longint rv[3], yt[3], rb[3];
      point_type p;
      theta = start_ang + 24'(beam * beam_step);
      plat  = 24'(scan * plat_step);
      ct = cosine_of(theta); st = sine_of(theta);
      cp = cosine_of(plat);  sp = sine_of(plat);
      cy = cosine_of(yaw);   sy = sine_of(yaw);
      xl = round_shift(longint'(range) * ct, 5);
      yl = round_shift(longint'(range) * st, 5);
      for (int i = 0; i < 3; i++) rv[i] = round_shift(LP_M[i][0] * xl + LP_M[i][1] * yl, 22);
      rv[2] += -16384;
      yt[0] = round_shift(-rv[1] * cp + rv[2] * sp, 17);
      yt[1] = round_shift(-rv[1] * sp - rv[2] * cp, 17);
      yt[2] = rv[0];
      for (int i = 0; i < 3; i++)
         rb[i] = round_shift(PR_M[i][0] * yt[0] + PR_M[i][1] * yt[1] + PR_M[i][2] * yt[2], 22)
                 + PR_T[i];
      xe = round_shift(rb[0] * cy - rb[1] * sy, 17);
      ye = round_shift(rb[0] * sy + rb[1] * cy, 17);
      p.x = clamp24(round_shift(xe, 12) + px);
      p.y = clamp24(round_shift(ye, 12) + py);
      p.z = clamp24(round_shift(rb[2], 12) + pz);
      return p;
   endfunction

   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         start_ang  <= lpw_pkg::START_ANGLE_RST;
         beam_step  <= lpw_pkg::BEAM_STEP_RST;
         plat_step  <= lpw_pkg::PLATFORM_STEP_RST;
         fail_count     = 0;
         points_seen    = 0;
         points_pending = 0;
         wr_ptr         = '0;
         rd_ptr         = '0;
      end else begin
         if (req_valid && req_ready) begin
            expected_mem[wr_ptr] = world_point(req_range_mm, req_beam_index, req_scan_index,
                                               req_pose_x, req_pose_y, req_pose_z,
                                               req_pose_yaw);
            wr_ptr = wr_ptr + 6'd1;
            points_pending++;
         end
         if (rsp_valid && rsp_ready) begin
            points_seen++;
            if (points_pending == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected point word at %0t", $time);
            end else begin
               e = expected_mem[rd_ptr];
               rd_ptr = rd_ptr + 6'd1;
               points_pending--;
               if (e.x !== rsp_point_x || e.y !== rsp_point_y || e.z !== rsp_point_z) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("point mismatch at %0t: exp %0d %0d %0d got %0d %0d %0d", $time,
                              e.x, e.y, e.z, rsp_point_x, rsp_point_y, rsp_point_z);
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               lpw_pkg::CSR_START_ANGLE:   start_ang <= csr_data;
               lpw_pkg::CSR_BEAM_STEP:     beam_step <= csr_data;
               lpw_pkg::CSR_PLATFORM_STEP: plat_step <= csr_data;
               default: ;
            endcase
         end
      end
   end
endmodule

`default_nettype wire

>>> sim/laser_point_to_world_transform_top_test.sv
// Top-level testbench: drives laser samples and register writes, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none

module laser_point_to_world_transform_top_test;

   // index with no register behind it
   localparam logic [lpw_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, rsp_ready = 1'b0;
   logic req_ready, rsp_valid;
   logic [15:0] req_range_mm = '0, req_scan_index = '0;
   logic [10:0] req_beam_index = '0;
   logic signed [23:0] req_pose_x = '0, req_pose_y = '0, req_pose_z = '0, req_pose_yaw = '0;
   logic signed [23:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic csr_write_en = 1'b0;
   logic [lpw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [23:0] csr_data = '0;
   int fail_count, points_pending, points_seen;
   int words_sent = 0;

   always #10 clock = ~clock;

   laser_point_to_world_transform_top u_top (.*);
   laser_point_to_world_transform_checker u_checker (.*);

   // mostly short gaps, now and then a long one; a quarter of the time none at all
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random back-pressure on rsp_ready
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         g = gap_length();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // one sample word, held until taken; valid stays up when the next follows at once
   task automatic send_sample(logic [15:0] range, logic [10:0] beam, logic [15:0] scan,
                              logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                              logic [23:0] yaw);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_range_mm <= range; req_beam_index <= beam; req_scan_index <= scan;
      req_pose_x <= px; req_pose_y <= py; req_pose_z <= pz; req_pose_yaw <= yaw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [lpw_pkg::CSR_INDEX_W-1:0] idx, logic [23:0] value);
      csr_write_en <= 1'b1; csr_index <= idx; csr_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // stop sending, wait for every expected point plus pipeline slack
   task automatic drain();
      req_valid <= 1'b0;
      while (points_pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   // random word: poses sometimes near full scale to drive saturation
   task automatic send_random();
      logic [23:0] px, py, pz;
      if ($urandom_range(0, 4) == 0) begin
         px = $urandom_range(0, 1) ? 24'h7FFFF0 : 24'h800010;
         py = $urandom_range(0, 1) ? 24'h7FFF00 : 24'h800100;
         pz = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      end else begin
         px = 24'($urandom); py = 24'($urandom); pz = 24'($urandom);
      end
      send_sample(16'($urandom), 11'($urandom), 16'($urandom), px, py, pz, 24'($urandom));
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset registers, field extremes
      send_sample(16'd0, 11'd0, 16'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      send_sample(16'hFFFF, 11'd0, 16'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      send_sample(16'hFFFF, 11'h7FF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_sample(16'hFFFF, 11'h7FF, 16'hFFFF, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
      send_sample(16'd1000, 11'd540, 16'd1, 24'd0, 24'd0, 24'd0, 24'h400000);
      send_sample(16'd1000, 11'd1080, 16'd2, 24'd100, 24'hFFFF9C, 24'd5, 24'hC00000);
      drain();
      // beam angle wrap, platform angle wrap, extreme register values
      write_reg(lpw_pkg::CSR_START_ANGLE, 24'h7FFFFF);
      write_reg(lpw_pkg::CSR_BEAM_STEP, 24'hFFFFFF);
      write_reg(lpw_pkg::CSR_PLATFORM_STEP, 24'hFFFFFF);
      write_reg(CSR_UNMAPPED, 24'h123456); // must be ignored
      send_sample(16'd3000, 11'h7FF, 16'hFFFF, 24'd0, 24'd0, 24'd0, 24'd0);
      send_sample(16'd3000, 11'd1, 16'd3, 24'd0, 24'd0, 24'd0, 24'h200000);
      send_sample(16'hFFFF, 11'd0, 16'd0, 24'h7FFFFF, 24'h800000, 24'd0, 24'd0);
      drain();
      write_reg(lpw_pkg::CSR_START_ANGLE, 24'h800000);
      write_reg(lpw_pkg::CSR_BEAM_STEP, 24'd0);
      write_reg(lpw_pkg::CSR_PLATFORM_STEP, 24'h400000);
      for (int q = 0; q < 4; q++)
         send_sample(16'd2000, 11'd7, 16'(q), 24'd0, 24'd0, 24'd0, 24'(q) << 22);
      drain();

      // random phases with varying register settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(lpw_pkg::CSR_START_ANGLE,
                   ph == 0 ? lpw_pkg::START_ANGLE_RST : 24'($urandom));
         write_reg(lpw_pkg::CSR_BEAM_STEP,
                   ph == 0 ? lpw_pkg::BEAM_STEP_RST : 24'($urandom));
         write_reg(lpw_pkg::CSR_PLATFORM_STEP,
                   ph == 5 ? 24'hFFFFFF : 24'($urandom_range(0, 65535)));
         repeat (100) send_random();
         drain();
      end

      $display("Sent %0d sample words over 9 register settings; %0d world points checked.",
               words_sent, points_seen);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout after %0d points", points_seen);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

`default_nettype wire
